[rtl/rlsf_pkg.sv]
// ----------------------------------------------------------------------------
// rlsf_pkg
// Shared types and constants for the reciprocal least-squares fit block.
// ----------------------------------------------------------------------------
package rlsf_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned SLOPE_W = 48;
  localparam int unsigned ICPT_W  = 32;
  localparam int unsigned PU_W    = 10;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_FIT   = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_DIV_RECIP,
    DP_T_SAVE,
    DP_MUL_TT,
    DP_ACC_TT,
    DP_MUL_TY,
    DP_ACC_PT,
    DP_MUL_N_STT,
    DP_MUL_ST_ST,
    DP_MUL_N_STY,
    DP_MUL_ST_SY,
    DP_MUL_STT_SY,
    DP_MUL_ST_STY,
    DP_HOLD,
    DP_DIFF_D,
    DP_DIFF_SL,
    DP_DIFF_IC,
    DP_DIV_NUM,
    DP_SAT_SL,
    DP_SAT_IC,
    DP_ZERO,
    DP_PUBLISH
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // multiplier or divider running
    logic can_add;   // captured reading nonzero and room for a point
    logic den_zero;  // fit denominator is zero
    logic out_free;  // result register can take a new item
  } dp_stat_t;

endpackage

[rtl/rlsf_dp.sv]
// ----------------------------------------------------------------------------
// rlsf_dp
// Datapath: running sums, shared shift-add multiplier, restoring divider,
// saturation and the result register.
// ----------------------------------------------------------------------------
module rlsf_dp
  import rlsf_pkg::*;
#(
  parameter int unsigned MAX_POINTS      = 1023,
  parameter int unsigned RECIP_FRAC_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_fire_i,
  input  logic [RAW_W-1:0]         raw_reading_i,
  input  logic [DIST_W-1:0]        distance_q8_i,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SLOPE_W-1:0] slope_q8_o,
  output logic signed [ICPT_W-1:0]  intercept_q8_o,
  output logic                     degenerate_o,
  output logic [PU_W-1:0]          points_used_o
);

  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW    = RECIP_FRAC_BITS + 1;
  localparam int unsigned ST_W  = TW + CW;
  localparam int unsigned SY_W  = DIST_W + CW;
  localparam int unsigned STT_W = 2 * TW + CW;
  localparam int unsigned STY_W = TW + DIST_W + CW;
  localparam int unsigned W     = 2 * TW + 2 * CW + DIST_W;
  localparam int unsigned DC_W  = $clog2(W + 1);
  localparam int unsigned SXW   = W + SLOPE_W;
  localparam int unsigned IXW   = W + ICPT_W;

  localparam logic [SXW-1:0] SL_LIM = SXW'(1) << (SLOPE_W - 1);
  localparam logic [IXW-1:0] IC_LIM = IXW'(1) << (ICPT_W - 1);

  logic [RAW_W-1:0]  raw_q;
  logic [DIST_W-1:0] y_q;
  logic [CW-1:0]     cnt_q;
  logic [ST_W-1:0]   st_q;
  logic [SY_W-1:0]   sy_q;
  logic [STT_W-1:0]  stt_q;
  logic [STY_W-1:0]  sty_q;
  logic [TW-1:0]     t_q;
  logic [W-1:0]      a_q, b_q, p_q, hold_q, den_q;
  logic [DC_W-1:0]   dcnt_q;
  logic              mul_run_q, div_run_q, neg_q;
  logic [SLOPE_W-1:0] slope_q;
  logic [ICPT_W-1:0]  icpt_q;
  logic               degen_q;

  logic [W:0]     r2;
  logic           ge;
  logic [W:0]     r2_sub;
  logic           hold_ge;
  logic [W-1:0]   diff_mag;
  logic [SXW-1:0] sqx;
  logic [IXW-1:0] iqx;
  logic [SLOPE_W-1:0] sl_sat;
  logic [ICPT_W-1:0]  ic_sat;
  logic [PU_W+CW-1:0] cnt_ext;

  always_comb begin
    r2       = {p_q, b_q[W-1]};
    ge       = r2 >= {1'b0, den_q};
    r2_sub   = r2 - {1'b0, den_q};
    hold_ge  = hold_q >= p_q;
    diff_mag = hold_ge ? (hold_q - p_q) : (p_q - hold_q);
    sqx      = {{SLOPE_W{1'b0}}, b_q};
    iqx      = {{ICPT_W{1'b0}}, b_q};
    if (!neg_q) begin
      sl_sat = (sqx > SL_LIM - SXW'(1)) ? SL_LIM[SLOPE_W-1:0] - SLOPE_W'(1)
                                         : sqx[SLOPE_W-1:0];
      ic_sat = (iqx > IC_LIM - IXW'(1)) ? IC_LIM[ICPT_W-1:0] - ICPT_W'(1)
                                         : iqx[ICPT_W-1:0];
    end else begin
      sl_sat = (sqx > SL_LIM) ? SL_LIM[SLOPE_W-1:0] : SLOPE_W'(0) - sqx[SLOPE_W-1:0];
      ic_sat = (iqx > IC_LIM) ? IC_LIM[ICPT_W-1:0] : ICPT_W'(0) - iqx[ICPT_W-1:0];
    end
    cnt_ext = {{PU_W{1'b0}}, cnt_q};
  end

  assign stat_o.busy     = mul_run_q | div_run_q;
  assign stat_o.can_add  = (raw_q != '0) && (cnt_q < CW'(MAX_POINTS));
  assign stat_o.den_zero = (den_q == '0);
  assign stat_o.out_free = !out_valid_o || out_ready_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      st_q        <= '0;
      sy_q        <= '0;
      stt_q       <= '0;
      sty_q       <= '0;
      mul_run_q   <= 1'b0;
      div_run_q   <= 1'b0;
      dcnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (mul_run_q && b_q == '0) mul_run_q <= 1'b0;
      if (div_run_q) begin
        dcnt_q <= dcnt_q - DC_W'(1);
        if (dcnt_q == DC_W'(1)) div_run_q <= 1'b0;
      end
      if (out_ready_i) out_valid_o <= 1'b0;
      case (cmd_i.op)
        DP_CLEAR: begin
          cnt_q <= '0;
          st_q  <= '0;
          sy_q  <= '0;
          stt_q <= '0;
          sty_q <= '0;
        end
        DP_ACC_TT: stt_q <= stt_q + p_q[STT_W-1:0];
        DP_ACC_PT: begin
          sty_q <= sty_q + p_q[STY_W-1:0];
          st_q  <= st_q + ST_W'(t_q);
          sy_q  <= sy_q + SY_W'(y_q);
          cnt_q <= cnt_q + CW'(1);
        end
        DP_MUL_TT, DP_MUL_TY, DP_MUL_N_STT, DP_MUL_ST_ST,
        DP_MUL_N_STY, DP_MUL_ST_SY, DP_MUL_STT_SY, DP_MUL_ST_STY: mul_run_q <= 1'b1;
        DP_DIV_RECIP, DP_DIV_NUM: begin
          div_run_q <= 1'b1;
          dcnt_q    <= DC_W'(W);
        end
        DP_PUBLISH: out_valid_o <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      raw_q <= raw_reading_i;
      y_q   <= distance_q8_i;
    end
    if (mul_run_q && b_q != '0) begin
      if (b_q[0]) p_q <= p_q + a_q;
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
    if (div_run_q) begin
      p_q <= ge ? r2_sub[W-1:0] : r2[W-1:0];
      b_q <= {b_q[W-2:0], ge};
    end
    case (cmd_i.op)
      DP_DIV_RECIP: begin
        den_q <= W'(raw_q);
        b_q   <= W'(1) << RECIP_FRAC_BITS;
        p_q   <= '0;
      end
      DP_DIV_NUM: begin
        b_q <= hold_q;
        p_q <= '0;
      end
      DP_T_SAVE: t_q <= b_q[TW-1:0];
      DP_MUL_TT: begin
        a_q <= W'(t_q);
        b_q <= W'(t_q);
        p_q <= '0;
      end
      DP_MUL_TY: begin
        a_q <= W'(t_q);
        b_q <= W'(y_q);
        p_q <= '0;
      end
      DP_MUL_N_STT: begin
        a_q <= W'(stt_q);
        b_q <= W'(cnt_q);
        p_q <= '0;
      end
      DP_MUL_ST_ST: begin
        a_q <= W'(st_q);
        b_q <= W'(st_q);
        p_q <= '0;
      end
      DP_MUL_N_STY: begin
        a_q <= W'(sty_q);
        b_q <= W'(cnt_q);
        p_q <= '0;
      end
      DP_MUL_ST_SY: begin
        a_q <= W'(st_q);
        b_q <= W'(sy_q);
        p_q <= '0;
      end
      DP_MUL_STT_SY: begin
        a_q <= W'(stt_q);
        b_q <= W'(sy_q);
        p_q <= '0;
      end
      DP_MUL_ST_STY: begin
        a_q <= W'(st_q);
        b_q <= W'(sty_q);
        p_q <= '0;
      end
      DP_HOLD: hold_q <= p_q;
      DP_DIFF_D: den_q <= diff_mag;
      DP_DIFF_SL: begin
        hold_q <= diff_mag << RECIP_FRAC_BITS;
        neg_q  <= !hold_ge;
      end
      DP_DIFF_IC: begin
        hold_q <= diff_mag;
        neg_q  <= !hold_ge;
      end
      DP_SAT_SL: slope_q <= sl_sat;
      DP_SAT_IC: begin
        icpt_q  <= ic_sat;
        degen_q <= 1'b0;
      end
      DP_ZERO: begin
        slope_q <= '0;
        icpt_q  <= '0;
        degen_q <= 1'b1;
      end
      DP_PUBLISH: begin
        slope_q8_o     <= slope_q;
        intercept_q8_o <= icpt_q;
        degenerate_o   <= degen_q;
        points_used_o  <= cnt_ext[PU_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

[rtl/rlsf_ctrl.sv]
// ----------------------------------------------------------------------------
// rlsf_ctrl
// Sequencer: accepts items and steps the datapath through add and fit.
// ----------------------------------------------------------------------------
module rlsf_ctrl
  import rlsf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] op_i,
  input  dp_stat_t        stat_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_ADD_CHK, S_T_SAVE, S_MUL_TT, S_ACC_TT, S_MUL_TY, S_ACC_PT,
    S_M1, S_H1, S_M2, S_D, S_D2, S_CHK,
    S_M3, S_H3, S_M4, S_N1, S_V1, S_S1,
    S_M5, S_H5, S_M6, S_N2, S_V2, S_S2, S_EMIT
  } state_e;

  state_e  state_q, ret_q;
  dp_cmd_t cmd_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      cmd_q.op <= DP_NOP;
    end else begin
      cmd_q.op <= DP_NOP;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (op_e'(op_i))
              OP_CLEAR: cmd_q.op <= DP_CLEAR;
              OP_ADD:   state_q  <= S_ADD_CHK;
              OP_FIT:   state_q  <= S_M1;
              default:  ;
            endcase
          end
        end
        // hold until the started unit is done
        S_WAIT: begin
          if (cmd_q.op == DP_NOP && !stat_i.busy) state_q <= ret_q;
        end
        S_ADD_CHK: begin
          if (stat_i.can_add) begin
            cmd_q.op <= DP_DIV_RECIP;
            ret_q    <= S_T_SAVE;
            state_q  <= S_WAIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_T_SAVE: begin
          cmd_q.op <= DP_T_SAVE;
          state_q  <= S_MUL_TT;
        end
        S_MUL_TT: begin
          cmd_q.op <= DP_MUL_TT;
          ret_q    <= S_ACC_TT;
          state_q  <= S_WAIT;
        end
        S_ACC_TT: begin
          cmd_q.op <= DP_ACC_TT;
          state_q  <= S_MUL_TY;
        end
        S_MUL_TY: begin
          cmd_q.op <= DP_MUL_TY;
          ret_q    <= S_ACC_PT;
          state_q  <= S_WAIT;
        end
        S_ACC_PT: begin
          cmd_q.op <= DP_ACC_PT;
          state_q  <= S_IDLE;
        end
        S_M1: begin
          cmd_q.op <= DP_MUL_N_STT;
          ret_q    <= S_H1;
          state_q  <= S_WAIT;
        end
        S_H1: begin
          cmd_q.op <= DP_HOLD;
          state_q  <= S_M2;
        end
        S_M2: begin
          cmd_q.op <= DP_MUL_ST_ST;
          ret_q    <= S_D;
          state_q  <= S_WAIT;
        end
        S_D: begin
          cmd_q.op <= DP_DIFF_D;
          state_q  <= S_D2;
        end
        // let the denominator land before testing it
        S_D2: state_q <= S_CHK;
        S_CHK: begin
          if (stat_i.den_zero) begin
            cmd_q.op <= DP_ZERO;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_M3;
          end
        end
        S_M3: begin
          cmd_q.op <= DP_MUL_N_STY;
          ret_q    <= S_H3;
          state_q  <= S_WAIT;
        end
        S_H3: begin
          cmd_q.op <= DP_HOLD;
          state_q  <= S_M4;
        end
        S_M4: begin
          cmd_q.op <= DP_MUL_ST_SY;
          ret_q    <= S_N1;
          state_q  <= S_WAIT;
        end
        S_N1: begin
          cmd_q.op <= DP_DIFF_SL;
          state_q  <= S_V1;
        end
        S_V1: begin
          cmd_q.op <= DP_DIV_NUM;
          ret_q    <= S_S1;
          state_q  <= S_WAIT;
        end
        S_S1: begin
          cmd_q.op <= DP_SAT_SL;
          state_q  <= S_M5;
        end
        S_M5: begin
          cmd_q.op <= DP_MUL_STT_SY;
          ret_q    <= S_H5;
          state_q  <= S_WAIT;
        end
        S_H5: begin
          cmd_q.op <= DP_HOLD;
          state_q  <= S_M6;
        end
        S_M6: begin
          cmd_q.op <= DP_MUL_ST_STY;
          ret_q    <= S_N2;
          state_q  <= S_WAIT;
        end
        S_N2: begin
          cmd_q.op <= DP_DIFF_IC;
          state_q  <= S_V2;
        end
        S_V2: begin
          cmd_q.op <= DP_DIV_NUM;
          ret_q    <= S_S2;
          state_q  <= S_WAIT;
        end
        S_S2: begin
          cmd_q.op <= DP_SAT_IC;
          state_q  <= S_EMIT;
        end
        S_EMIT: begin
          if (stat_i.out_free) begin
            cmd_q.op <= DP_PUBLISH;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/reciprocal_least_squares_fit.sv]
// ----------------------------------------------------------------------------
// reciprocal_least_squares_fit
// Least-squares fit of distance = a/raw + b over calibration points.
// ----------------------------------------------------------------------------
// A clear item only resets the running sums. An add item runs one restoring
// division for the reciprocal, W bits wide (W = 2*(RECIP_FRAC_BITS+1) +
// 2*clog2(MAX_POINTS+1) + 16, 86 at the defaults), and two shift-add
// multiplications that stop after the multiplier's highest set bit. A fit item
// runs six multiplications and two divisions on the same shared units; a
// degenerate fit stops after the denominator check. One item is worked on at
// a time; the result register holds a finished fit while the next item is
// taken, and a fit that finishes while that register is still full holds the
// input until the waiting result is taken.
// ----------------------------------------------------------------------------
module reciprocal_least_squares_fit
  import rlsf_pkg::*;
#(
  parameter int unsigned MAX_POINTS      = 1023,
  parameter int unsigned RECIP_FRAC_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [OP_W-1:0]           op_i,
  input  logic [RAW_W-1:0]          raw_reading_i,
  input  logic [DIST_W-1:0]         distance_q8_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SLOPE_W-1:0] slope_q8_o,
  output logic signed [ICPT_W-1:0]  intercept_q8_o,
  output logic                      degenerate_o,
  output logic [PU_W-1:0]           points_used_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;

  assign in_fire = in_valid_i & in_ready_o;

  rlsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rlsf_dp #(
    .MAX_POINTS      (MAX_POINTS),
    .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .raw_reading_i  (raw_reading_i),
    .distance_q8_i  (distance_q8_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slope_q8_o     (slope_q8_o),
    .intercept_q8_o (intercept_q8_o),
    .degenerate_o   (degenerate_o),
    .points_used_o  (points_used_o)
  );

endmodule

[rtl/rlsf_checker.sv]
// ----------------------------------------------------------------------------
// rlsf_checker
// Port-level checks for the reciprocal least-squares fit block.
// ----------------------------------------------------------------------------
module rlsf_checker
  import rlsf_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [OP_W-1:0]           op_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [SLOPE_W-1:0] slope_q8_o,
  input logic signed [ICPT_W-1:0]  intercept_q8_o,
  input logic                      degenerate_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(slope_q8_o) && $stable(intercept_q8_o))
    else $error("result changed while stalled");

  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_ADD || op_i == OP_FIT) |=> !in_ready_o)
    else $error("ready while an add or fit item is in progress");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> slope_q8_o == '0 && intercept_q8_o == '0)
    else $error("degenerate fit with nonzero coefficients");

endmodule

bind reciprocal_least_squares_fit rlsf_checker u_rlsf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .op_i           (op_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .slope_q8_o     (slope_q8_o),
  .intercept_q8_o (intercept_q8_o),
  .degenerate_o   (degenerate_o)
);
